// ===== rtl/core/mf3_pkg.sv =====
// Shared types, constants and the three-input sort helper of the 3x3 median filter.
`default_nettype none
package mf3_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W  = 8;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WCFG_W = 12;
    localparam int HCFG_W = 13;

    // Widths in which counters and register values are compared.
    localparam int W_CMP_W = (WCFG_W > COL_W + 1) ? WCFG_W : COL_W + 1;
    localparam int H_CMP_W = (HCFG_W > ROW_W + 1) ? HCFG_W : ROW_W + 1;

    localparam int OUT_BITS    = PIX_W + ROW_W + COL_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [WCFG_W-1:0] WIDTH_RESET  = WCFG_W'(640);
    localparam logic [HCFG_W-1:0] HEIGHT_RESET = HCFG_W'(480);

    // Register index, taken from paddr[2].
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] grey;
        logic [COL_W-1:0] addr;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             emit;
        logic             last;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } tag_t;

    typedef struct packed {
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] hi;
    } trio_t;

    function automatic trio_t sort3(input logic [PIX_W-1:0] a,
                                    input logic [PIX_W-1:0] b,
                                    input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] l0;
        logic [PIX_W-1:0] h0;
        logic [PIX_W-1:0] l1;
        logic [PIX_W-1:0] h1;
        logic [PIX_W-1:0] l2;
        logic [PIX_W-1:0] h2;
        trio_t t;
        l0 = (a < b) ? a : b;
        h0 = (a < b) ? b : a;
        l1 = (h0 < c) ? h0 : c;
        h1 = (h0 < c) ? c : h0;
        l2 = (l0 < l1) ? l0 : l1;
        h2 = (l0 < l1) ? l1 : l0;
        t.lo  = l2;
        t.mid = h2;
        t.hi  = h1;
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mf3_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
`default_nettype none
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mf3_front.sv =====
// Front end: accepts pixels, tracks row and column, and tags each pixel for the back end.
`default_nettype none
module mf3_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [mf3_pkg::WCFG_W-1:0]   width_cfg,
    input  wire logic [mf3_pkg::HCFG_W-1:0]   height_cfg,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [mf3_pkg::PIX_W-1:0]    in_grey,
    input  wire logic                         in_frame_start,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output mf3_pkg::item_t                    push_item
);

    logic [mf3_pkg::COL_W-1:0]   col_cnt_reg;
    logic [mf3_pkg::COL_W-1:0]   col_cnt_next;
    logic [mf3_pkg::ROW_W-1:0]   row_cnt_reg;
    logic [mf3_pkg::ROW_W-1:0]   row_cnt_next;
    logic [mf3_pkg::W_CMP_W-1:0] w_lim;
    logic [mf3_pkg::H_CMP_W-1:0] h_lim;
    logic [mf3_pkg::W_CMP_W-1:0] w_cfg_x;
    logic [mf3_pkg::H_CMP_W-1:0] h_cfg_x;
    logic [mf3_pkg::COL_W-1:0]   c;
    logic [mf3_pkg::ROW_W-1:0]   r;
    logic [mf3_pkg::W_CMP_W-1:0] c_x;
    logic [mf3_pkg::H_CMP_W-1:0] r_x;
    logic                        accept;

    assign w_cfg_x = mf3_pkg::W_CMP_W'(width_cfg);
    assign h_cfg_x = mf3_pkg::H_CMP_W'(height_cfg);

    // Saturate the programmed frame size to the supported range.
    always_comb
    begin
        if (w_cfg_x < mf3_pkg::W_CMP_W'(3))
        begin
            w_lim = mf3_pkg::W_CMP_W'(3);
        end
        else if (w_cfg_x > mf3_pkg::W_CMP_W'(mf3_pkg::MAX_WIDTH))
        begin
            w_lim = mf3_pkg::W_CMP_W'(mf3_pkg::MAX_WIDTH);
        end
        else
        begin
            w_lim = w_cfg_x;
        end
        if (h_cfg_x < mf3_pkg::H_CMP_W'(3))
        begin
            h_lim = mf3_pkg::H_CMP_W'(3);
        end
        else if (h_cfg_x > mf3_pkg::H_CMP_W'(mf3_pkg::MAX_HEIGHT))
        begin
            h_lim = mf3_pkg::H_CMP_W'(mf3_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_lim = h_cfg_x;
        end
    end

    assign c   = in_frame_start ? '0 : col_cnt_reg;
    assign r   = in_frame_start ? '0 : row_cnt_reg;
    assign c_x = mf3_pkg::W_CMP_W'(c);
    assign r_x = mf3_pkg::H_CMP_W'(r);

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    always_comb
    begin
        push_item.grey = in_grey;
        push_item.addr = c;
        push_item.row  = r - mf3_pkg::ROW_W'(1);
        push_item.col  = c - mf3_pkg::COL_W'(1);
        push_item.emit = (r >= mf3_pkg::ROW_W'(2)) && (c >= mf3_pkg::COL_W'(2))
                         && (r_x < h_lim) && (c_x < w_lim);
        push_item.last = (r_x == h_lim - mf3_pkg::H_CMP_W'(1))
                         && (c_x == w_lim - mf3_pkg::W_CMP_W'(1));
    end

    // Past a lowered limit, a column wraps at its next advance, a row at a column wrap.
    always_comb
    begin
        if (c_x + mf3_pkg::W_CMP_W'(1) >= w_lim)
        begin
            col_cnt_next = '0;
            if (r_x + mf3_pkg::H_CMP_W'(1) >= h_lim)
            begin
                row_cnt_next = '0;
            end
            else
            begin
                row_cnt_next = r + mf3_pkg::ROW_W'(1);
            end
        end
        else
        begin
            col_cnt_next = c + mf3_pkg::COL_W'(1);
            row_cnt_next = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (accept)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mf3_queue.sv =====
// Short FIFO of tagged pixels between the front end and the back end.
`default_nettype none
module mf3_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire mf3_pkg::item_t push_item,
    output logic                head_valid,
    input  wire logic           head_take,
    output mf3_pkg::item_t      head_item
);

    mf3_pkg::item_t              entry_reg [mf3_pkg::Q_DEPTH];
    logic [mf3_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [mf3_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [mf3_pkg::Q_CNT_W-1:0] count_reg;
    logic [mf3_pkg::Q_CNT_W-1:0] count_next;
    logic                        push;
    logic                        pop;

    assign push_ready = (count_reg != mf3_pkg::Q_CNT_W'(mf3_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = head_take && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + mf3_pkg::Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - mf3_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + mf3_pkg::Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + mf3_pkg::Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mf3_pkg::Q_CNT_W'(mf3_pkg::Q_DEPTH))
        else $error("queue fill count exceeds its depth");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/mf3_back.sv =====
// Back end: line stores, 3x3 window and the pipelined median-of-nine network.
`default_nettype none
module mf3_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        head_valid,
    input  wire mf3_pkg::item_t              head_item,
    output logic                             head_take,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [mf3_pkg::PIX_W-1:0]        out_median,
    output mf3_pkg::tag_t                    out_tag
);

    logic                      adv;
    logic                      s1_valid_reg;
    mf3_pkg::item_t            s1_reg;
    logic                      fwd_reg;
    logic [mf3_pkg::PIX_W-1:0] fwd_up_reg;
    logic [mf3_pkg::PIX_W-1:0] fwd_mid_reg;
    logic [mf3_pkg::PIX_W-1:0] upper_q;
    logic [mf3_pkg::PIX_W-1:0] middle_q;
    logic [mf3_pkg::PIX_W-1:0] up_eff;
    logic [mf3_pkg::PIX_W-1:0] mid_eff;
    logic [mf3_pkg::PIX_W-1:0] win_reg [9];
    logic                      s2_valid_reg;
    mf3_pkg::tag_t             s2_tag_reg;
    logic                      s3_valid_reg;
    mf3_pkg::tag_t             s3_tag_reg;
    mf3_pkg::trio_t            rows_reg [3];
    logic                      s4_valid_reg;
    mf3_pkg::tag_t             s4_tag_reg;
    logic [mf3_pkg::PIX_W-1:0] max_lo_reg;
    logic [mf3_pkg::PIX_W-1:0] med_mid_reg;
    logic [mf3_pkg::PIX_W-1:0] min_hi_reg;
    mf3_pkg::trio_t            lo_sort;
    mf3_pkg::trio_t            mid_sort;
    mf3_pkg::trio_t            hi_sort;
    mf3_pkg::trio_t            final_sort;
    logic                      out_valid_reg;
    logic [mf3_pkg::PIX_W-1:0] out_median_reg;
    mf3_pkg::tag_t             out_tag_reg;

    // The whole back pipeline moves together unless the output beat is held.
    assign adv       = !out_valid_reg || out_ready;
    assign head_take = adv;

    // Each line store is read when a pixel enters stage one and written when it leaves.
    mf3_ram #(.WIDTH(mf3_pkg::PIX_W), .DEPTH(mf3_pkg::MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (adv && s1_valid_reg),
        .waddr (s1_reg.addr),
        .wdata (mid_eff),
        .re    (adv),
        .raddr (head_item.addr),
        .rdata (upper_q)
    );

    mf3_ram #(.WIDTH(mf3_pkg::PIX_W), .DEPTH(mf3_pkg::MAX_WIDTH)) u_middle (
        .clk   (clk),
        .we    (adv && s1_valid_reg),
        .waddr (s1_reg.addr),
        .wdata (s1_reg.grey),
        .re    (adv),
        .raddr (head_item.addr),
        .rdata (middle_q)
    );

    // A read that coincided with a write to the same column takes the written values.
    assign up_eff  = fwd_reg ? fwd_up_reg  : upper_q;
    assign mid_eff = fwd_reg ? fwd_mid_reg : middle_q;

    assign lo_sort    = mf3_pkg::sort3(rows_reg[0].lo,  rows_reg[1].lo,  rows_reg[2].lo);
    assign mid_sort   = mf3_pkg::sort3(rows_reg[0].mid, rows_reg[1].mid, rows_reg[2].mid);
    assign hi_sort    = mf3_pkg::sort3(rows_reg[0].hi,  rows_reg[1].hi,  rows_reg[2].hi);
    assign final_sort = mf3_pkg::sort3(max_lo_reg, med_mid_reg, min_hi_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= head_valid;
            fwd_reg       <= s1_valid_reg && head_valid && (s1_reg.addr == head_item.addr);
            s2_valid_reg  <= s1_valid_reg && s1_reg.emit;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    // The window shifts by one column for every pixel, emitted or not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (adv && s1_valid_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k * 3]     <= win_reg[k * 3 + 1];
                win_reg[k * 3 + 1] <= win_reg[k * 3 + 2];
            end
            win_reg[2] <= up_eff;
            win_reg[5] <= mid_eff;
            win_reg[8] <= s1_reg.grey;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg      <= head_item;
            fwd_up_reg  <= mid_eff;
            fwd_mid_reg <= s1_reg.grey;

            s2_tag_reg.row  <= s1_reg.row;
            s2_tag_reg.col  <= s1_reg.col;
            s2_tag_reg.last <= s1_reg.last;

            s3_tag_reg <= s2_tag_reg;
            for (int k = 0; k < 3; k++)
            begin
                rows_reg[k] <= mf3_pkg::sort3(win_reg[k * 3], win_reg[k * 3 + 1],
                                              win_reg[k * 3 + 2]);
            end

            s4_tag_reg  <= s3_tag_reg;
            max_lo_reg  <= lo_sort.hi;
            med_mid_reg <= mid_sort.mid;
            min_hi_reg  <= hi_sort.lo;

            out_tag_reg    <= s4_tag_reg;
            out_median_reg <= final_sort.mid;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_median = out_median_reg;
    assign out_tag    = out_tag_reg;

`ifndef SYNTHESIS
    a_out_from_s4: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s4_valid_reg))
        else $error("output beat appeared without a pixel in the last stage");
    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_tag_reg.row != '0) && (out_tag_reg.col != '0))
        else $error("output beat names a border pixel");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/median_filter_3x3.sv =====
// Top level of the streaming 3x3 median filter with its register port.
// The filter takes one 8-bit pixel per clock in raster order and sustains one pixel
// per clock unless the output stalls; each pixel passes a tagging front end, a
// four-entry queue and a back pipeline whose line stores are read and written once
// per pixel. A result beat passes the window, sort and output registers, and only
// interior pixels give a beat: border pixels give none. The median is always taken
// over the unfiltered pixels. Program image_width (address 0) and image_height
// (address 4) only while no pixel is in flight; values are saturated to 3..2048
// and 3..4096. The line stores need no clearing after reset.
`default_nettype none
module median_filter_3x3 (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mf3_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [mf3_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [mf3_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                    pready,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [mf3_pkg::PIX_W-1:0]          s_tdata,   // grey
    input  wire logic                               s_tuser,   // frame_start
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [mf3_pkg::OUT_TDATA_W-1:0]         m_tdata,   // median_grey, row, col
    output logic                                    m_tlast    // last_of_frame
);

    logic [mf3_pkg::WCFG_W-1:0] width_reg;
    logic [mf3_pkg::HCFG_W-1:0] height_reg;
    logic                       push_valid;
    logic                       push_ready;
    mf3_pkg::item_t             push_item;
    logic                       head_valid;
    logic                       head_take;
    mf3_pkg::item_t             head_item;
    logic [mf3_pkg::PIX_W-1:0]  out_median;
    mf3_pkg::tag_t              out_tag;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mf3_pkg::WIDTH_RESET;
            height_reg <= mf3_pkg::HEIGHT_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                mf3_pkg::CFG_IDX_WIDTH:  width_reg  <= pwdata[mf3_pkg::WCFG_W-1:0];
                mf3_pkg::CFG_IDX_HEIGHT: height_reg <= pwdata[mf3_pkg::HCFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            mf3_pkg::CFG_IDX_WIDTH:  prdata = mf3_pkg::CFG_DATA_W'(width_reg);
            mf3_pkg::CFG_IDX_HEIGHT: prdata = mf3_pkg::CFG_DATA_W'(height_reg);
            default:                 prdata = '0;
        endcase
    end

    mf3_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .width_cfg      (width_reg),
        .height_cfg     (height_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_grey        (s_tdata),
        .in_frame_start (s_tuser),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_item      (push_item)
    );

    mf3_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .head_valid (head_valid),
        .head_take  (head_take),
        .head_item  (head_item)
    );

    mf3_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_take  (head_take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_median (out_median),
        .out_tag    (out_tag)
    );

    assign m_tdata = mf3_pkg::OUT_TDATA_W'({out_tag.col, out_tag.row, out_median});
    assign m_tlast = out_tag.last;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the streaming 3x3 median filter.
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 20;

    typedef struct packed {
        logic                      last;
        logic [mf3_pkg::COL_W-1:0] col;
        logic [mf3_pkg::ROW_W-1:0] row;
        logic [mf3_pkg::PIX_W-1:0] median;
    } median_beat_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [mf3_pkg::CFG_ADDR_W-1:0]  paddr = '0;
    logic [mf3_pkg::CFG_DATA_W-1:0]  pwdata = '0;
    logic [mf3_pkg::CFG_DATA_W-1:0]  prdata;
    logic                            pready;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [mf3_pkg::PIX_W-1:0]       s_tdata = '0;    // grey
    logic                            s_tuser = 1'b0;  // frame_start
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [mf3_pkg::OUT_TDATA_W-1:0] m_tdata;         // median_grey, row, col
    logic                            m_tlast;         // last_of_frame

    median_filter_3x3 dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Filter state as the block should hold it.
    logic [mf3_pkg::WCFG_W-1:0] width_reg  = mf3_pkg::WIDTH_RESET;
    logic [mf3_pkg::HCFG_W-1:0] height_reg = mf3_pkg::HEIGHT_RESET;
    logic [mf3_pkg::PIX_W-1:0]  upper_line [mf3_pkg::MAX_WIDTH];
    logic [mf3_pkg::PIX_W-1:0]  middle_line [mf3_pkg::MAX_WIDTH];
    logic [mf3_pkg::PIX_W-1:0]  win [9];
    int unsigned                col_pos = 0;
    int unsigned                row_pos = 0;

    median_beat_t pending_medians[$];
    int n_pixels  = 0;
    int n_medians = 0;
    int n_errors  = 0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    logic hold_req = 1'b0;
    int hold_cnt = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [mf3_pkg::PIX_W-1:0] middle_of_nine(
        input logic [mf3_pkg::PIX_W-1:0] px [9]);
        logic [mf3_pkg::PIX_W-1:0] v [9];
        logic [mf3_pkg::PIX_W-1:0] t;
        int j;
        v = px;
        for (int i = 1; i < 9; i++) begin
            t = v[i];
            j = i - 1;
            while (j >= 0 && v[j] > t) begin
                v[j + 1] = v[j];
                j--;
            end
            v[j + 1] = t;
        end
        return v[4];
    endfunction

    function automatic void filter_pixel(input logic [mf3_pkg::PIX_W-1:0] grey, input logic fs);
        int unsigned w;
        int unsigned h;
        logic [mf3_pkg::PIX_W-1:0] up;
        logic [mf3_pkg::PIX_W-1:0] mid;
        median_beat_t beat;
        w = (width_reg < 3) ? 3 :
            ((width_reg > mf3_pkg::MAX_WIDTH) ? mf3_pkg::MAX_WIDTH : width_reg);
        h = (height_reg < 3) ? 3 :
            ((height_reg > mf3_pkg::MAX_HEIGHT) ? mf3_pkg::MAX_HEIGHT : height_reg);
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        up  = (col_pos < mf3_pkg::MAX_WIDTH) ? upper_line[col_pos] : '0;
        mid = (col_pos < mf3_pkg::MAX_WIDTH) ? middle_line[col_pos] : '0;
        for (int k = 0; k < 3; k++)
        begin
            win[3*k]     = win[3*k + 1];
            win[3*k + 1] = win[3*k + 2];
        end
        win[2] = up;
        win[5] = mid;
        win[8] = grey;
        if (col_pos < mf3_pkg::MAX_WIDTH)
        begin
            upper_line[col_pos]  = mid;
            middle_line[col_pos] = grey;
        end
        // The pixel completes the window centered one row up and one column left.
        if (row_pos >= 2 && col_pos >= 2 && row_pos < h && col_pos < w)
        begin
            beat.median = middle_of_nine(win);
            beat.row    = mf3_pkg::ROW_W'(row_pos - 1);
            beat.col    = mf3_pkg::COL_W'(col_pos - 1);
            beat.last   = (row_pos == h - 1) && (col_pos == w - 1);
            pending_medians.push_back(beat);
        end
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
    endfunction

    // Result side: checks every accepted beat, stalls at random and holds off on request.
    always @(posedge clk)
    begin
        median_beat_t got;
        median_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tlast, m_tdata[mf3_pkg::OUT_BITS-1:0]};
            n_medians++;
            if (pending_medians.size() == 0)
            begin
                $error("unexpected result beat: median %0d row %0d col %0d last %0b",
                       got.median, got.row, got.col, got.last);
                n_errors++;
            end
            else
            begin
                want = pending_medians.pop_front();
                if (got.median !== want.median)
                begin
                    $error("median_grey mismatch: expected %0d, got %0d", want.median, got.median);
                    n_errors++;
                end
                if (got.row !== want.row)
                begin
                    $error("row mismatch: expected %0d, got %0d", want.row, got.row);
                    n_errors++;
                end
                if (got.col !== want.col)
                begin
                    $error("col mismatch: expected %0d, got %0d", want.col, got.col);
                    n_errors++;
                end
                if (got.last !== want.last)
                begin
                    $error("last_of_frame mismatch: expected %0b, got %0b", want.last, got.last);
                    n_errors++;
                end
            end
        end
        if (!hold_req)
            hold_cnt = 0;
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_req && hold_cnt < HOLD_CYCLES)
        begin
            hold_cnt++;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic send_pixel(input logic [mf3_pkg::PIX_W-1:0] grey, input logic fs);
        s_tvalid <= 1'b1;
        s_tdata  <= grey;
        s_tuser  <= fs;
        do @(posedge clk); while (!s_tready);
        filter_pixel(grey, fs);
        n_pixels++;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            if (s_tvalid)
                s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic stop_stream();
        if (s_tvalid)
            s_tvalid <= 1'b0;
    endtask

    task automatic stream_frame(input int unsigned n_pix, input bit with_start,
                                input int noise_pct);
        logic fs;
        for (int unsigned k = 0; k < n_pix; k++)
        begin
            fs = (with_start && k == 0) || ($urandom_range(0, 99) < noise_pct);
            send_pixel(mf3_pkg::PIX_W'($urandom_range(0, 255)), fs);
        end
    endtask

    // Waits for every expected beat, then lets the pipeline settle.
    task automatic wait_for_medians();
        stop_stream();
        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic read_reg(input logic idx, input logic [mf3_pkg::CFG_DATA_W-1:0] want);
        logic [mf3_pkg::CFG_DATA_W-1:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
        begin
            $error("register %0d readback mismatch: expected %0d, got %0d", idx, want, got);
            n_errors++;
        end
    endtask

    task automatic write_reg(input logic idx, input logic [mf3_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == mf3_pkg::CFG_IDX_WIDTH)
        begin
            width_reg = value[mf3_pkg::WCFG_W-1:0];
            read_reg(idx, mf3_pkg::CFG_DATA_W'(width_reg));
        end
        else
        begin
            height_reg = value[mf3_pkg::HCFG_W-1:0];
            read_reg(idx, mf3_pkg::CFG_DATA_W'(height_reg));
        end
    endtask

    task automatic set_traffic(input int idle_pct, input int stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct <= stall_pct;
    endtask

    task automatic test_register_reset_values();
        read_reg(mf3_pkg::CFG_IDX_WIDTH, mf3_pkg::CFG_DATA_W'(mf3_pkg::WIDTH_RESET));
        read_reg(mf3_pkg::CFG_IDX_HEIGHT, mf3_pkg::CFG_DATA_W'(mf3_pkg::HEIGHT_RESET));
    endtask

    // The first pixels at the power-up geometry lie on the top border and give no beat.
    task automatic test_reset_geometry();
        set_traffic(0, 0);
        stream_frame(40, 1'b1, 0);
        wait_for_medians();
    endtask

    // Smallest frames with extreme grey levels, a frame that starts by counter
    // wrap, and a frame start that cuts a frame short.
    task automatic test_smallest_frames();
        logic [mf3_pkg::PIX_W-1:0] ramp [9] = '{8'd70, 8'd10, 8'd90, 8'd30, 8'd50,
                                                8'd20, 8'd80, 8'd40, 8'd60};
        write_reg(mf3_pkg::CFG_IDX_WIDTH, 3);
        write_reg(mf3_pkg::CFG_IDX_HEIGHT, 3);
        for (int k = 0; k < 9; k++)
            send_pixel((k % 2) ? 8'hFF : 8'h00, k == 0);
        for (int k = 0; k < 9; k++)
            send_pixel((k % 2) ? 8'h00 : 8'hFF, 1'b0);
        for (int k = 0; k < 4; k++)
            send_pixel(8'hFF, 1'b0);
        for (int k = 0; k < 9; k++)
            send_pixel(ramp[k], k == 0);
        wait_for_medians();
    endtask

    task automatic test_clamp_low();
        write_reg(mf3_pkg::CFG_IDX_WIDTH, 0);
        write_reg(mf3_pkg::CFG_IDX_HEIGHT, 2);
        stream_frame(9, 1'b1, 0);
        wait_for_medians();
    endtask

    // Shrinks both limits while the counters sit beyond them.
    task automatic test_mid_frame_change();
        write_reg(mf3_pkg::CFG_IDX_WIDTH, 8);
        write_reg(mf3_pkg::CFG_IDX_HEIGHT, 6);
        stream_frame(3 * 8 + 6, 1'b1, 0);
        wait_for_medians();
        write_reg(mf3_pkg::CFG_IDX_WIDTH, 4);
        write_reg(mf3_pkg::CFG_IDX_HEIGHT, 3);
        stream_frame(1 + 2 * 4 * 3, 1'b0, 0);
        wait_for_medians();
    endtask

    // An oversized width saturates, so the start of a long top row gives no beat.
    task automatic test_widest();
        set_traffic(0, 0);
        write_reg(mf3_pkg::CFG_IDX_WIDTH, 4095);
        write_reg(mf3_pkg::CFG_IDX_HEIGHT, 3);
        stream_frame(24, 1'b1, 0);
        wait_for_medians();
    endtask

    // An oversized height saturates, so rows keep counting past small heights.
    task automatic test_tallest();
        set_traffic(0, 0);
        write_reg(mf3_pkg::CFG_IDX_WIDTH, 2);
        write_reg(mf3_pkg::CFG_IDX_HEIGHT, 8191);
        stream_frame(3 * 12, 1'b1, 0);
        wait_for_medians();
    endtask

    // The sink holds off long enough for the block to fill and stall its input.
    task automatic test_backpressure();
        set_traffic(0, 0);
        write_reg(mf3_pkg::CFG_IDX_WIDTH, 6);
        write_reg(mf3_pkg::CFG_IDX_HEIGHT, 5);
        hold_req <= 1'b1;
        stream_frame(3 * 30, 1'b1, 0);
        hold_req <= 1'b0;
        wait_for_medians();
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int quota);
        int start_count;
        int unsigned w;
        int unsigned h;
        int pick;
        bit first;
        wait_for_medians();
        set_traffic(idle_pct, stall_pct);
        w = $urandom_range(3, 12);
        h = $urandom_range(3, 8);
        if ($urandom_range(0, 9) == 0)
            w = $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0)
            h = $urandom_range(0, 2);
        write_reg(mf3_pkg::CFG_IDX_WIDTH, w);
        write_reg(mf3_pkg::CFG_IDX_HEIGHT, h);
        w = (w < 3) ? 3 : w;
        h = (h < 3) ? 3 : h;
        start_count = n_pixels;
        first = 1'b1;
        while (n_pixels - start_count < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                stream_frame($urandom_range(1, w * h - 1), 1'b1, 0);
            else
                stream_frame(w * h, first || pick < 80, 1);
            first = 1'b0;
        end
        wait_for_medians();
    endtask

    task automatic test_random_traffic();
        for (int rep = 0; rep < 2; rep++)
        begin
            run_random_phase(0, 0, 30);
            run_random_phase(48, 0, 30);
            run_random_phase(0, 48, 30);
            run_random_phase(16, 16, 30);
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_reset_values();
        test_reset_geometry();
        test_smallest_frames();
        test_clamp_low();
        test_mid_frame_change();
        test_widest();
        test_tallest();
        test_backpressure();
        test_random_traffic();
        wait_for_medians();
        $display("Streamed %0d pixels and checked %0d medians over small frames, saturated",
                 n_pixels, n_medians);
        $display("limits, limit changes mid-frame, restarts, idle gaps and output stalls.");
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #500_000;
        $display("Timeout: %0d medians still expected", pending_medians.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
